### rtl/mlex_pkg.sv
// Shared types, token codes and character helpers of the mini C lexer.
package mlex_pkg;

    // Token kinds
    localparam logic [2:0] KIND_OP     = 3'd0;
    localparam logic [2:0] KIND_IDENT  = 3'd1;
    localparam logic [2:0] KIND_NUM    = 3'd2;
    localparam logic [2:0] KIND_RETURN = 3'd3;
    localparam logic [2:0] KIND_IF     = 3'd4;
    localparam logic [2:0] KIND_ELSE   = 3'd5;
    localparam logic [2:0] KIND_EOF    = 3'd6;
    localparam logic [2:0] KIND_ERR    = 3'd7;

    // Operator codes
    localparam logic [3:0] OP_PLUS  = 4'd0;
    localparam logic [3:0] OP_MINUS = 4'd1;
    localparam logic [3:0] OP_MUL   = 4'd2;
    localparam logic [3:0] OP_DIV   = 4'd3;
    localparam logic [3:0] OP_LPAR  = 4'd4;
    localparam logic [3:0] OP_RPAR  = 4'd5;
    localparam logic [3:0] OP_LT    = 4'd6;
    localparam logic [3:0] OP_GT    = 4'd7;
    localparam logic [3:0] OP_ASSIGN = 4'd8;
    localparam logic [3:0] OP_SEMI  = 4'd9;
    localparam logic [3:0] OP_EQ    = 4'd10;
    localparam logic [3:0] OP_NE    = 4'd11;
    localparam logic [3:0] OP_LE    = 4'd12;
    localparam logic [3:0] OP_GE    = 4'd13;

    // Keyword candidate bits
    localparam int unsigned KW_RETURN = 0;
    localparam int unsigned KW_IF     = 1;
    localparam int unsigned KW_ELSE   = 2;
    localparam logic [2:0]  KW_ALL    = 3'b111;
    localparam logic [15:0] KW_RETURN_LEN = 16'd6;
    localparam logic [15:0] KW_IF_LEN     = 16'd2;
    localparam logic [15:0] KW_ELSE_LEN   = 16'd4;

    localparam logic [62:0] NUM_MAX = {63{1'b1}};

    typedef struct packed {
        logic       req_type;
        logic [7:0] ch;
    } t_lex_req;

    typedef struct packed {
        logic [2:0]  tok_kind;
        logic [3:0]  op_code;
        logic [15:0] start_pos;
        logic [15:0] tok_len;
        logic [62:0] num_value;
        logic        last_of_run;
    } t_lex_tok;

    // Results of one character: how many, and the tokens in order
    typedef struct packed {
        logic [1:0] count;
        t_lex_tok   tok0;
        t_lex_tok   tok1;
    } t_core_res;

    function automatic logic is_space(logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0D]};
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"], "_"};
    endfunction

    function automatic logic is_single_op(logic [7:0] c);
        return c inside {"+", "-", "*", "/", "(", ")", "<", ">", "=", ";"};
    endfunction

    function automatic logic [3:0] single_op_code(logic [7:0] c);
        logic [3:0] code;
        case (c)
            "+":     code = OP_PLUS;
            "-":     code = OP_MINUS;
            "*":     code = OP_MUL;
            "/":     code = OP_DIV;
            "(":     code = OP_LPAR;
            ")":     code = OP_RPAR;
            "<":     code = OP_LT;
            ">":     code = OP_GT;
            "=":     code = OP_ASSIGN;
            default: code = OP_SEMI;
        endcase
        return code;
    endfunction

    // Keyword character at a position; zero past the keyword's end
    function automatic logic [7:0] kw_char(int unsigned k, logic [2:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        case (k)
            KW_RETURN: begin
                case (idx)
                    3'd0:    ch = "r";
                    3'd1:    ch = "e";
                    3'd2:    ch = "t";
                    3'd3:    ch = "u";
                    3'd4:    ch = "r";
                    3'd5:    ch = "n";
                    default: ch = 8'h00;
                endcase
            end
            KW_IF: begin
                case (idx)
                    3'd0:    ch = "i";
                    3'd1:    ch = "f";
                    default: ch = 8'h00;
                endcase
            end
            default: begin
                case (idx)
                    3'd0:    ch = "e";
                    3'd1:    ch = "l";
                    3'd2:    ch = "s";
                    3'd3:    ch = "e";
                    default: ch = 8'h00;
                endcase
            end
        endcase
        return ch;
    endfunction

    // Drop keyword candidates that disagree with the character at idx
    function automatic logic [2:0] kw_update(logic [2:0] kw, logic [2:0] idx, logic [7:0] c);
        logic [2:0] res;
        res = kw;
        for (int unsigned k = 0; k < 3; k++) begin
            if (kw_char(k, idx) != c) res[k] = 1'b0;
        end
        return res;
    endfunction

    // acc * 10 + d, saturating at the largest 63-bit value
    function automatic logic [62:0] num_step(logic [62:0] acc, logic [3:0] d);
        logic [66:0] wide;
        wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {63'b0, d};
        return (wide[66:63] != 4'b0) ? NUM_MAX : wide[62:0];
    endfunction

endpackage

### rtl/mini_c_lexer.sv
// Top level of the mini C lexer: input register, lexer core and token queue.
//
//  channel | valid       | stall        | payload                      | dir
//  input   | i_in_valid  | o_in_stall   | i_in_data  (t_lex_req)       | in
//  output  | o_out_valid | i_out_stall  | o_out_data (t_lex_tok)       | out
//
// One character per cycle while the queue has room; a character with two tokens needs
// two output transfers, so one token per unstalled output cycle sets the sustained rate.
// A character is registered in the input register and its tokens in the queue.
// Reset is synchronous (i_rst_n low) and clears lexer state and the queue.
// Input stalls while a character is held and the queue has fewer than two free entries.
module mini_c_lexer #(
    parameter int unsigned MAX_INPUT_LEN = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mlex_pkg::t_lex_req i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mlex_pkg::t_lex_tok o_out_data
);

    localparam int unsigned Depth = 4;
    localparam int unsigned PtrW  = $clog2(Depth);
    localparam int unsigned CntW  = PtrW + 1;

    logic                r_in_valid;
    mlex_pkg::t_lex_req  r_in_data;
    mlex_pkg::t_core_res res;
    logic                proc;
    logic                pop;
    logic [1:0]          push_n;

    mlex_pkg::t_lex_tok  r_fifo [Depth];
    logic [PtrW-1:0]     r_wr, r_rd;
    logic [CntW-1:0]     r_count, n_count;

    // Process the held character when at least two queue entries are free
    assign proc   = r_in_valid && (r_count <= CntW'(Depth - 2));
    assign push_n = proc ? res.count : 2'd0;
    assign pop    = o_out_valid && !i_out_stall;

    assign o_in_stall  = r_in_valid && !proc;
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_fifo[r_rd];

    assign n_count = r_count + CntW'(push_n) - CntW'(pop);

    mlex_core #(
        .MAX_INPUT_LEN(MAX_INPUT_LEN)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (proc),
        .i_req   (r_in_data),
        .o_res   (res)
    );

    // Capture an input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_data <= i_in_data;
        end
    end

    // Write up to two tokens into the queue
    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_fifo[r_wr] <= res.tok0;
        end
        if (push_n == 2'd2) begin
            r_fifo[r_wr + PtrW'(1)] <= res.tok1;
        end
    end

    // Advance queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PtrW'(push_n);
            r_rd    <= r_rd + PtrW'(pop);
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(Depth))
        else $error("token queue overflow");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count) + CntW'($past(push_n)) - CntW'($past(pop))))
        else $error("token queue count out of step with pushes and pops");

endmodule

### rtl/mlex_core.sv
// Lexer state and per-character token decision of the mini C lexer.
module mlex_core #(
    parameter int unsigned MAX_INPUT_LEN = 65536
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  mlex_pkg::t_lex_req  i_req,
    output mlex_pkg::t_core_res o_res
);

    localparam int unsigned LimInt = (MAX_INPUT_LEN - 1 < 65535) ? MAX_INPUT_LEN - 1 : 65535;
    localparam logic [15:0] PosLimit = 16'(LimInt);

    typedef enum logic [1:0] {MODE_IDLE, MODE_IDENT, MODE_NUM, MODE_OP} t_mode;
    typedef enum logic [1:0] {PEND_LT, PEND_GT, PEND_EQ, PEND_NOT} t_pend;

    t_mode       r_mode, n_mode;
    t_pend       r_pend, n_pend;
    logic [15:0] r_pos, n_pos;
    logic [15:0] r_start, n_start;
    logic [15:0] r_len, n_len;
    logic [62:0] r_acc, n_acc;
    logic [2:0]  r_kw, n_kw;

    logic               eof;
    logic [7:0]         c;
    logic [2:0]         kw_idx;
    logic               f_valid, b_valid;
    mlex_pkg::t_lex_tok f_tok, b_tok;

    function automatic logic [15:0] sat_inc(logic [15:0] v);
        return (v < PosLimit) ? v + 16'd1 : PosLimit;
    endfunction

    assign c      = i_req.ch;
    assign eof    = i_req.req_type || (c == 8'h00);
    assign kw_idx = (r_len < 16'd8) ? r_len[2:0] : 3'd7;

    // Token that the pending state turns into when it is closed
    always_comb begin
        f_tok = '0;
        f_tok.start_pos = r_start;
        case (r_mode)
            MODE_IDENT: begin
                f_tok.tok_kind = mlex_pkg::KIND_IDENT;
                if (r_kw[mlex_pkg::KW_RETURN] && r_len == mlex_pkg::KW_RETURN_LEN)
                    f_tok.tok_kind = mlex_pkg::KIND_RETURN;
                if (r_kw[mlex_pkg::KW_IF] && r_len == mlex_pkg::KW_IF_LEN)
                    f_tok.tok_kind = mlex_pkg::KIND_IF;
                if (r_kw[mlex_pkg::KW_ELSE] && r_len == mlex_pkg::KW_ELSE_LEN)
                    f_tok.tok_kind = mlex_pkg::KIND_ELSE;
                f_tok.tok_len = r_len;
            end
            MODE_NUM: begin
                f_tok.tok_kind  = mlex_pkg::KIND_NUM;
                f_tok.tok_len   = r_len;
                f_tok.num_value = r_acc;
            end
            MODE_OP: begin
                f_tok.tok_len = 16'd1;
                case (r_pend)
                    PEND_LT: begin
                        f_tok.tok_kind = mlex_pkg::KIND_OP;
                        f_tok.op_code  = mlex_pkg::OP_LT;
                    end
                    PEND_GT: begin
                        f_tok.tok_kind = mlex_pkg::KIND_OP;
                        f_tok.op_code  = mlex_pkg::OP_GT;
                    end
                    PEND_EQ: begin
                        f_tok.tok_kind = mlex_pkg::KIND_OP;
                        f_tok.op_code  = mlex_pkg::OP_ASSIGN;
                    end
                    default: f_tok.tok_kind = mlex_pkg::KIND_ERR;
                endcase
            end
            default: f_tok = '0;
        endcase
    end

    // Decide the next state and the second token of this character
    always_comb begin
        n_mode  = r_mode;
        n_pend  = r_pend;
        n_pos   = r_pos;
        n_start = r_start;
        n_len   = r_len;
        n_acc   = r_acc;
        n_kw    = r_kw;
        f_valid = 1'b0;
        b_valid = 1'b0;
        b_tok   = '0;
        if (i_go) begin
            if (eof) begin
                f_valid         = (r_mode != MODE_IDLE);
                b_valid         = 1'b1;
                b_tok.tok_kind  = mlex_pkg::KIND_EOF;
                b_tok.start_pos = r_pos;
                n_mode  = MODE_IDLE;
                n_pend  = PEND_LT;
                n_pos   = '0;
                n_start = '0;
                n_len   = '0;
                n_acc   = '0;
                n_kw    = mlex_pkg::KW_ALL;
            end else begin
                n_pos = sat_inc(r_pos);
                if (r_mode == MODE_IDENT &&
                    (mlex_pkg::is_alpha(c) || mlex_pkg::is_digit(c))) begin
                    n_kw  = mlex_pkg::kw_update(r_kw, kw_idx, c);
                    n_len = sat_inc(r_len);
                end else if (r_mode == MODE_NUM && mlex_pkg::is_digit(c)) begin
                    n_acc = mlex_pkg::num_step(r_acc, c[3:0]);
                    n_len = sat_inc(r_len);
                end else if (r_mode == MODE_OP && c == "=") begin
                    b_valid         = 1'b1;
                    b_tok.tok_kind  = mlex_pkg::KIND_OP;
                    b_tok.start_pos = r_start;
                    b_tok.tok_len   = 16'd2;
                    case (r_pend)
                        PEND_EQ:  b_tok.op_code = mlex_pkg::OP_EQ;
                        PEND_NOT: b_tok.op_code = mlex_pkg::OP_NE;
                        PEND_LT:  b_tok.op_code = mlex_pkg::OP_LE;
                        default:  b_tok.op_code = mlex_pkg::OP_GE;
                    endcase
                    n_mode = MODE_IDLE;
                    n_pend = PEND_LT;
                end else begin
                    // close the pending token, then start on this character
                    f_valid = (r_mode != MODE_IDLE);
                    n_mode  = MODE_IDLE;
                    n_len   = '0;
                    n_acc   = '0;
                    n_kw    = mlex_pkg::KW_ALL;
                    n_pend  = PEND_LT;
                    if (!mlex_pkg::is_space(c)) begin
                        n_start = r_pos;
                        if (mlex_pkg::is_alpha(c)) begin
                            n_mode = MODE_IDENT;
                            n_len  = 16'd1;
                            n_kw   = mlex_pkg::kw_update(mlex_pkg::KW_ALL, 3'd0, c);
                        end else if (mlex_pkg::is_digit(c)) begin
                            n_mode = MODE_NUM;
                            n_len  = 16'd1;
                            n_acc  = {59'b0, c[3:0]};
                        end else if (c == "<" || c == ">" || c == "=" || c == "!") begin
                            n_mode = MODE_OP;
                            case (c)
                                "<":     n_pend = PEND_LT;
                                ">":     n_pend = PEND_GT;
                                "=":     n_pend = PEND_EQ;
                                default: n_pend = PEND_NOT;
                            endcase
                        end else begin
                            b_valid         = 1'b1;
                            b_tok.start_pos = r_pos;
                            b_tok.tok_len   = 16'd1;
                            if (mlex_pkg::is_single_op(c)) begin
                                b_tok.tok_kind = mlex_pkg::KIND_OP;
                                b_tok.op_code  = mlex_pkg::single_op_code(c);
                            end else begin
                                b_tok.tok_kind = mlex_pkg::KIND_ERR;
                            end
                        end
                    end
                end
            end
        end
    end

    // Pack the tokens in order and mark the last one
    always_comb begin
        o_res = '0;
        if (f_valid) begin
            o_res.tok0 = f_tok;
            o_res.tok1 = b_tok;
            o_res.tok0.last_of_run = !b_valid;
            o_res.tok1.last_of_run = 1'b1;
            o_res.count = b_valid ? 2'd2 : 2'd1;
        end else if (b_valid) begin
            o_res.tok0 = b_tok;
            o_res.tok0.last_of_run = 1'b1;
            o_res.count = 2'd1;
        end
    end

    // Hold lexer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_pend  <= PEND_LT;
            r_pos   <= '0;
            r_start <= '0;
            r_len   <= '0;
            r_acc   <= '0;
            r_kw    <= mlex_pkg::KW_ALL;
        end else begin
            r_mode  <= n_mode;
            r_pend  <= n_pend;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_len   <= n_len;
            r_acc   <= n_acc;
            r_kw    <= n_kw;
        end
    end

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_IDLE || r_mode == MODE_OP) |-> (r_len == 16'd0 && r_acc == 63'd0))
        else $error("idle or operator state carries a length or value");

    a_word_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_IDENT || r_mode == MODE_NUM) |-> (r_len != 16'd0))
        else $error("open word token with zero length");

    a_eof_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && eof) |=> (r_pos == 16'd0 && r_mode == MODE_IDLE))
        else $error("end of input did not restart the position");

endmodule

### tb/mini_c_lexer_test.sv
// Self-checking testbench for the mini C lexer: stimulus queue, token prediction and checking.
module mini_c_lexer_test;

    localparam int unsigned ITEM_GOAL   = 1900;
    localparam int unsigned LONG_IDENT  = 40;
    localparam int unsigned HOLD_AT     = 600;
    localparam int unsigned HOLD_LEN    = 300;
    localparam int unsigned STUCK_LIMIT = 4000;
    localparam logic [15:0] POS_CEIL    = 16'hFFFF;
    localparam logic [15:0] LONG_LEN    = 16'd8;
    localparam logic [3:0]  OP_NONE     = 4'd0;

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_IDENT, SCAN_NUM, SCAN_OP} t_scan;

    typedef struct {
        mlex_pkg::t_lex_req req;
        int unsigned        gap;
        bit                 drain;
    } t_char_item;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    mlex_pkg::t_lex_req in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    mlex_pkg::t_lex_tok out_data;

    string kw_word [3] = '{"return", "if", "else"};
    string op_text [14] = '{"+", "-", "*", "/", "(", ")", "<", ">", "=", ";",
                            "==", "!=", "<=", ">="};
    string lead_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string word_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

    // Lexer state as predicted
    t_scan              scan_st = SCAN_IDLE;
    logic [15:0]        lex_pos = '0;
    logic [15:0]        lex_start = '0;
    logic [15:0]        lex_len = '0;
    logic [62:0]        lex_acc = '0;
    logic [2:0]         lex_kw = mlex_pkg::KW_ALL;
    logic [7:0]         lex_opch = '0;
    mlex_pkg::t_lex_tok step_toks[$];
    mlex_pkg::t_lex_tok toks_due[$];

    // Stimulus and bookkeeping
    t_char_item         char_q[$];
    t_char_item         drv_item;
    mlex_pkg::t_lex_tok want;
    bit                 gap_style = 1'b0;
    bit                 drain_next = 1'b0;
    bit                 hold_done = 1'b0;
    logic               in_took = 1'b0;
    int unsigned        item_cnt = 0;
    int unsigned        stall_left = 0;
    int unsigned        stall_pick = 0;
    int unsigned        cyc_cnt = 0;
    int unsigned        stuck_cnt = 0;
    int unsigned        in_cnt = 0;
    int unsigned        tok_cnt = 0;
    int unsigned        kw_cnt = 0;
    int unsigned        err_tok_cnt = 0;
    int unsigned        eof_cnt = 0;
    int unsigned        long_cnt = 0;
    int unsigned        err_cnt = 0;

    mini_c_lexer i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic logic chr_blank(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic chr_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic chr_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic [3:0] op_code_of(logic [7:0] c);
        case (c)
            "+":     return mlex_pkg::OP_PLUS;
            "-":     return mlex_pkg::OP_MINUS;
            "*":     return mlex_pkg::OP_MUL;
            "/":     return mlex_pkg::OP_DIV;
            "(":     return mlex_pkg::OP_LPAR;
            ")":     return mlex_pkg::OP_RPAR;
            "<":     return mlex_pkg::OP_LT;
            ">":     return mlex_pkg::OP_GT;
            "=":     return mlex_pkg::OP_ASSIGN;
            default: return mlex_pkg::OP_SEMI;
        endcase
    endfunction

    function automatic logic chr_single_op(logic [7:0] c);
        case (c)
            "+", "-", "*", "/", "(", ")", "<", ">", "=", ";": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [15:0] sat16(logic [15:0] v);
        return (v == POS_CEIL) ? v : v + 16'd1;
    endfunction

    // Append one decimal digit, clamping at the largest value
    function automatic logic [62:0] acc_digit(logic [62:0] acc, logic [7:0] c);
        logic [62:0] d;
        d = {55'd0, c - 8'h30};
        return (acc > (mlex_pkg::NUM_MAX - d) / 63'd10) ? mlex_pkg::NUM_MAX
                                                         : acc * 63'd10 + d;
    endfunction

    // Drop keyword candidates whose letter at idx differs from c
    function automatic logic [2:0] kw_narrow(logic [2:0] kw, logic [15:0] idx, logic [7:0] c);
        logic [2:0] res;
        res = kw;
        for (int k = 0; k < 3; k++) begin
            if (idx >= kw_word[k].len() || kw_word[k][int'(idx)] != c) res[k] = 1'b0;
        end
        return res;
    endfunction

    task automatic emit_tok(logic [2:0] kind, logic [3:0] op, logic [15:0] st,
                            logic [15:0] len, logic [62:0] val);
        mlex_pkg::t_lex_tok t;
        t.tok_kind    = kind;
        t.op_code     = op;
        t.start_pos   = st;
        t.tok_len     = len;
        t.num_value   = val;
        t.last_of_run = 1'b0;
        if (step_toks.size() < 2) step_toks.push_back(t);
    endtask

    task automatic lex_clear();
        scan_st   = SCAN_IDLE;
        lex_pos   = '0;
        lex_start = '0;
        lex_len   = '0;
        lex_acc   = '0;
        lex_kw    = mlex_pkg::KW_ALL;
        lex_opch  = '0;
    endtask

    // Emit whatever token is pending and return to idle
    task automatic flush_tok();
        logic [2:0] kind;
        case (scan_st)
            SCAN_IDENT: begin
                kind = mlex_pkg::KIND_IDENT;
                for (int k = 0; k < 3; k++) begin
                    if (lex_kw[k] && lex_len == kw_word[k].len())
                        kind = mlex_pkg::KIND_RETURN + 3'(k);
                end
                emit_tok(kind, OP_NONE, lex_start, lex_len, '0);
            end
            SCAN_NUM: emit_tok(mlex_pkg::KIND_NUM, OP_NONE, lex_start, lex_len, lex_acc);
            SCAN_OP: begin
                if (lex_opch == "!")
                    emit_tok(mlex_pkg::KIND_ERR, OP_NONE, lex_start, 16'd1, '0);
                else
                    emit_tok(mlex_pkg::KIND_OP, op_code_of(lex_opch), lex_start, 16'd1, '0);
            end
            default: ;
        endcase
        scan_st  = SCAN_IDLE;
        lex_len  = '0;
        lex_acc  = '0;
        lex_kw   = mlex_pkg::KW_ALL;
        lex_opch = '0;
    endtask

    // Open a new token on c, or emit it at once when it stands alone
    task automatic begin_tok(logic [7:0] c);
        if (chr_blank(c)) return;
        lex_start = lex_pos;
        if (chr_letter(c)) begin
            scan_st = SCAN_IDENT;
            lex_len = 16'd1;
            lex_kw  = kw_narrow(mlex_pkg::KW_ALL, 16'd0, c);
        end else if (chr_digit(c)) begin
            scan_st = SCAN_NUM;
            lex_len = 16'd1;
            lex_acc = acc_digit('0, c);
        end else if (c == "<" || c == ">" || c == "=" || c == "!") begin
            scan_st  = SCAN_OP;
            lex_opch = c;
        end else if (chr_single_op(c)) begin
            emit_tok(mlex_pkg::KIND_OP, op_code_of(c), lex_pos, 16'd1, '0);
        end else begin
            emit_tok(mlex_pkg::KIND_ERR, OP_NONE, lex_pos, 16'd1, '0);
        end
    endtask

    // Work out the tokens caused by one accepted transaction
    task automatic lex_char(mlex_pkg::t_lex_req r);
        logic [7:0] c;
        logic [3:0] op;
        c = r.ch;
        step_toks.delete();
        if (r.req_type || c == 8'h00) begin
            flush_tok();
            emit_tok(mlex_pkg::KIND_EOF, OP_NONE, lex_pos, 16'd0, '0);
            lex_clear();
        end else begin
            if (scan_st == SCAN_IDENT && (chr_letter(c) || chr_digit(c))) begin
                lex_kw  = kw_narrow(lex_kw, (lex_len < 16'd8) ? lex_len : 16'd7, c);
                lex_len = sat16(lex_len);
            end else if (scan_st == SCAN_NUM && chr_digit(c)) begin
                lex_acc = acc_digit(lex_acc, c);
                lex_len = sat16(lex_len);
            end else if (scan_st == SCAN_OP && c == "=") begin
                case (lex_opch)
                    "=":     op = mlex_pkg::OP_EQ;
                    "!":     op = mlex_pkg::OP_NE;
                    "<":     op = mlex_pkg::OP_LE;
                    default: op = mlex_pkg::OP_GE;
                endcase
                emit_tok(mlex_pkg::KIND_OP, op, lex_start, 16'd2, '0);
                scan_st  = SCAN_IDLE;
                lex_opch = '0;
            end else begin
                flush_tok();
                begin_tok(c);
            end
            lex_pos = sat16(lex_pos);
        end
        if (step_toks.size() != 0) step_toks[step_toks.size() - 1].last_of_run = 1'b1;
        foreach (step_toks[i]) toks_due.push_back(step_toks[i]);
    endtask

    task automatic cmp_field(string fname, logic [63:0] exp_v, logic [63:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: token %0d %s expected %0h actual %0h",
                     $time, tok_cnt, fname, exp_v, act_v);
            err_cnt++;
        end
    endtask

    // Stimulus helpers
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!gap_style) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic add_req(logic rt, logic [7:0] c);
        t_char_item it;
        it.req.req_type = rt;
        it.req.ch       = c;
        it.gap          = pick_gap();
        it.drain        = drain_next;
        drain_next      = 1'b0;
        char_q.push_back(it);
        item_cnt++;
    endtask

    task automatic add_char(logic [7:0] c);
        add_req(1'b0, c);
    endtask

    task automatic add_end();
        add_req(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) add_char(s[i]);
    endtask

    task automatic add_blank();
        int unsigned r;
        r = $urandom_range(8, 13);
        add_char((r == 8) ? 8'h20 : 8'(r));
    endtask

    task automatic add_word_tail(int unsigned n);
        repeat (n) add_char(word_set[$urandom_range(0, word_set.len() - 1)]);
    endtask

    task automatic add_digits(int unsigned n);
        repeat (n) add_char(8'h30 + 8'($urandom_range(0, 9)));
    endtask

    // One random token with an optional separator after it
    task automatic add_token();
        int unsigned r;
        int unsigned n;
        string kw;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            n  = $urandom_range(0, 9);
            kw = kw_word[$urandom_range(0, 2)];
            if (n < 3) begin
                add_text(kw);
            end else if (n == 3) begin
                add_text(kw);
                add_word_tail($urandom_range(1, 4));
            end else if (n == 4) begin
                add_text(kw.substr(0, kw.len() - 2));
            end else begin
                add_char(lead_set[$urandom_range(0, lead_set.len() - 1)]);
                add_word_tail($urandom_range(0, (n == 9) ? 12 : 4));
            end
        end else if (r < 50) begin
            n = $urandom_range(0, 49);
            if (n == 0) add_text("9223372036854775807");
            else if (n == 1) add_text("9223372036854775808");
            else add_digits((n < 5) ? $urandom_range(18, 24) : $urandom_range(1, 3));
        end else if (r < 80) begin
            add_text(op_text[$urandom_range(0, 13)]);
        end else if (r < 85) begin
            add_blank();
        end else if (r < 91) begin
            add_char("!");
        end else if (r < 97) begin
            add_char(8'($urandom_range(1, 255)));
        end else if ($urandom_range(0, 3) == 0) begin
            add_char(8'h00);
        end else begin
            add_end();
        end
        if ($urandom_range(0, 1) != 0) add_blank();
    endtask

    // Drive the next character at the falling edge; hold it while stalled
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_took) begin
            if (char_q.size() == 0) begin
                in_valid <= 1'b0;
            end else if (char_q[0].gap != 0) begin
                char_q[0].gap = char_q[0].gap - 1;
                in_valid <= 1'b0;
            end else if (char_q[0].drain && toks_due.size() != 0) begin
                in_valid <= 1'b0;
            end else begin
                drv_item = char_q.pop_front();
                in_valid <= 1'b1;
                in_data  <= drv_item.req;
            end
        end
    end

    // Stall the token output: quiet stretches, short bursts, one long hold-off
    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (stall_left != 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (!hold_done && in_cnt >= HOLD_AT) begin
            out_stall  <= 1'b1;
            stall_left <= HOLD_LEN;
            hold_done  <= 1'b1;
        end else begin
            stall_pick = $urandom_range(0, 99);
            if ((cyc_cnt / 1000) % 3 == 0 || stall_pick < 75) stall_pick = 0;
            else if (stall_pick < 95) stall_pick = $urandom_range(1, 3);
            else stall_pick = $urandom_range(8, 40);
            out_stall  <= (stall_pick != 0);
            stall_left <= (stall_pick == 0) ? 0 : stall_pick - 1;
        end
    end

    // Check outgoing tokens, then predict tokens of the incoming character
    always @(posedge clk) begin
        if (!rst_n) begin
            lex_clear();
            in_took <= 1'b0;
            stuck_cnt = 0;
        end else begin
            cyc_cnt++;
            if (out_valid && !out_stall) begin
                if (toks_due.size() == 0) begin
                    $display("%0t: token expected none actual kind %0d op %0d at %0d len %0d",
                             $time, out_data.tok_kind, out_data.op_code,
                             out_data.start_pos, out_data.tok_len);
                    err_cnt++;
                end else begin
                    want = toks_due.pop_front();
                    cmp_field("kind", want.tok_kind, out_data.tok_kind);
                    cmp_field("op", want.op_code, out_data.op_code);
                    cmp_field("start", want.start_pos, out_data.start_pos);
                    cmp_field("length", want.tok_len, out_data.tok_len);
                    cmp_field("value", {1'b0, want.num_value}, {1'b0, out_data.num_value});
                    cmp_field("last", want.last_of_run, out_data.last_of_run);
                    if (want.tok_kind == mlex_pkg::KIND_EOF) eof_cnt++;
                    if (want.tok_kind == mlex_pkg::KIND_ERR) err_tok_cnt++;
                    if (want.tok_kind inside {mlex_pkg::KIND_RETURN, mlex_pkg::KIND_IF,
                                              mlex_pkg::KIND_ELSE}) kw_cnt++;
                    if (want.tok_len >= LONG_LEN) long_cnt++;
                end
                tok_cnt++;
            end
            if (in_valid && !in_stall) begin
                lex_char(in_data);
                in_cnt++;
            end
            in_took <= in_valid && !in_stall;
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cnt = 0;
            else stuck_cnt++;
        end
    end

    // End the run when nothing moves for too long
    initial begin
        while (stuck_cnt < STUCK_LIMIT) @(negedge clk);
        $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int unsigned next_phase;
        // Keywords, operator pairs, lone bang, high byte, digits into letters, NUL end
        add_text("return+if!");
        add_char(8'hFF);
        add_text(" 12ab=");
        add_char(8'h00);
        add_char(8'h09);
        add_text("else<=>=!==(");
        add_char(8'h0D);
        add_text("iff");
        add_end();

        // Random token streams; switch idling style and pause for a drain now and then
        next_phase = item_cnt;
        while (item_cnt < ITEM_GOAL) begin
            if (item_cnt >= next_phase) begin
                gap_style  = ($urandom_range(0, 3) != 0);
                drain_next = 1'b1;
                next_phase += 250;
            end
            add_token();
        end

        // One long identifier that runs past the keyword letter positions
        gap_style  = 1'b0;
        drain_next = 1'b1;
        add_char("z");
        add_word_tail(LONG_IDENT);
        add_text(" 123+y");
        add_end();

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Wait for the stimulus to drain and the last tokens to arrive
        while (char_q.size() != 0 || in_valid) @(negedge clk);
        while (toks_due.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);

        if (toks_due.size() != 0) begin
            $display("%0t: %0d predicted tokens never arrived", $time, toks_due.size());
            err_cnt += toks_due.size();
        end
        $display("Run: %0d input transactions, %0d tokens compared", in_cnt, tok_cnt);
        $display("(%0d keywords, %0d errors, %0d eof, %0d tokens of eight or more characters).",
                 kw_cnt, err_tok_cnt, eof_cnt, long_cnt);
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
